@@ rtl/ics_pkg.sv @@
// shared constants and types for the in-order cooldown scheduler
package ics_pkg;

  localparam int unsigned MaxCooldown = 31;
  localparam int unsigned SymW        = 8;
  localparam int unsigned CdW         = $clog2(MaxCooldown + 1);
  localparam int unsigned RingDepth   = MaxCooldown + 1;
  localparam int unsigned RingAw      = $clog2(RingDepth);
  localparam int unsigned CntW        = $clog2(RingDepth + 1);
  localparam int unsigned EntryW      = SymW + 1;
  localparam int unsigned MapDepth    = 1 << SymW;
  localparam int unsigned ApbAw       = 3;

  // register index decoded from paddr[2]
  localparam logic CfgCooldown = 1'b0;

  // present map access from the slot controller
  typedef struct packed {
    logic            rd_en;
    logic [SymW-1:0] rd_addr;
    logic            set_en;
    logic [SymW-1:0] set_addr;
    logic            clr_en;
    logic [SymW-1:0] clr_addr;
  } map_req_t;

  // window ring access from the slot controller
  typedef struct packed {
    logic              rd_en;
    logic [RingAw-1:0] rd_addr;
    logic              wr_en;
    logic [RingAw-1:0] wr_addr;
    logic [EntryW-1:0] wr_data;
  } ring_req_t;

endpackage

@@ rtl/ics_cfg_regs.sv @@
// apb register file holding the cooldown setting
module ics_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ics_pkg::ApbAw-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [ics_pkg::CdW-1:0]   cooldown_o
);

  logic [ics_pkg::CdW-1:0] cooldown_q, cooldown_d;
  logic                    idx_cd;

  assign idx_cd = (paddr[2] == ics_pkg::CfgCooldown);
  assign pready = 1'b1;

  // write on the access phase
  always_comb begin
    cooldown_d = cooldown_q;
    if (psel && penable && pwrite && pready && idx_cd) begin
      cooldown_d = pwdata[ics_pkg::CdW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= '0;
    end else begin
      cooldown_q <= cooldown_d;
    end
  end

  // read back
  assign prdata     = idx_cd ? {{(32 - ics_pkg::CdW){1'b0}}, cooldown_q} : 32'd0;
  assign cooldown_o = cooldown_q;

endmodule

@@ rtl/ics_ring_ram.sv @@
// window ring memory, one write and one registered read port
module ics_ring_ram (
  input  logic                       clk_i,
  input  ics_pkg::ring_req_t         req_i,
  output logic [ics_pkg::EntryW-1:0] rdata_o
);

  logic [ics_pkg::EntryW-1:0] mem [ics_pkg::RingDepth];
  logic [ics_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ics_present_map.sv @@
// presence bitmap memory with per-entry valid bits and a deferred clear
module ics_present_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ics_pkg::map_req_t req_i,
  output logic              present_o
);

  logic                     mem [ics_pkg::MapDepth];
  logic [ics_pkg::MapDepth-1:0] vld_q, vld_d;
  logic                     pend_v_q, pend_v_d;
  logic [ics_pkg::SymW-1:0] pend_addr_q, pend_addr_d;
  logic                     rd_bit_q;
  logic                     rd_vld_q;
  logic                     hit_q;

  // a clear waits in a register; a set on the write port wins and drops it
  assign pend_v_d    = req_i.clr_en;
  assign pend_addr_d = req_i.clr_addr;

  always_comb begin
    vld_d = vld_q;
    if (req_i.set_en) begin
      vld_d[req_i.set_addr] = 1'b1;
    end else if (pend_v_q) begin
      vld_d[pend_addr_q] = 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.set_en) begin
      mem[req_i.set_addr] <= 1'b1;
    end else if (pend_v_q) begin
      mem[pend_addr_q] <= 1'b0;
    end
    if (req_i.rd_en) begin
      rd_bit_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      pend_v_q    <= 1'b0;
      pend_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      pend_v_q    <= pend_v_d;
      pend_addr_q <= pend_addr_d;
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
        hit_q    <= pend_v_q && (pend_addr_q == req_i.rd_addr);
      end
    end
  end

  // a clear landing in the read cycle wins over the stale bit
  assign present_o = rd_bit_q && rd_vld_q && !hit_q;

endmodule

@@ rtl/ics_slot_ctrl.sv @@
// slot sequencer: retire, presence check, push and output register
module ics_slot_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ics_pkg::CdW-1:0]    cooldown_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ics_pkg::SymW-1:0]   in_sym_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ics_pkg::SymW-1:0]   out_sym_o,
  output logic                       out_idle_o,
  output logic                       out_last_o,
  output ics_pkg::map_req_t          map_req_o,
  input  logic                       map_present_i,
  output ics_pkg::ring_req_t         ring_req_o,
  input  logic [ics_pkg::EntryW-1:0] ring_rdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StEval = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [ics_pkg::SymW-1:0]  sym_q, sym_d;
  logic [ics_pkg::RingAw-1:0] head_q, head_d;
  logic [ics_pkg::CntW-1:0]  count_q, count_d;
  logic                      out_v_q, out_v_d;
  logic [ics_pkg::SymW-1:0]  out_sym_q, out_sym_d;
  logic                      out_idle_q, out_idle_d;
  logic                      out_last_q, out_last_d;

  logic [ics_pkg::CntW-1:0]  cd_ext;
  logic                      retire;
  logic                      final_step;
  logic                      emit_ok;
  logic                      ent_idle;
  logic [ics_pkg::SymW-1:0]  ent_sym;
  logic                      busy;
  logic [ics_pkg::RingAw-1:0] head_nx;
  logic [ics_pkg::CntW-1:0]  count_nx;
  logic                      accept;

  assign cd_ext     = {{(ics_pkg::CntW - ics_pkg::CdW){1'b0}}, cooldown_i};
  assign retire     = count_q > cd_ext;
  assign final_step = count_q <= (cd_ext + ics_pkg::CntW'(1));
  assign emit_ok    = !out_v_q || out_ready_i;
  assign ent_idle   = ring_rdata_i[ics_pkg::SymW];
  assign ent_sym    = ring_rdata_i[ics_pkg::SymW-1:0];
  assign head_nx    = head_q + ics_pkg::RingAw'(retire);
  assign count_nx   = count_q - ics_pkg::CntW'(retire);
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // symbol still present unless the slot retiring now was its last copy
  assign busy = map_present_i && !(retire && !ent_idle && (ent_sym == sym_q));

  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    head_d     = head_q;
    count_d    = count_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_sym_d  = out_sym_q;
    out_idle_d = out_idle_q;
    out_last_d = out_last_q;
    map_req_o  = '0;
    ring_req_o = '0;

    unique case (state_q)
      StIdle: begin
        // reads start in the accept cycle
        if (accept) begin
          sym_d              = in_sym_i;
          map_req_o.rd_en    = 1'b1;
          map_req_o.rd_addr  = in_sym_i;
          ring_req_o.rd_en   = 1'b1;
          ring_req_o.rd_addr = head_q;
          state_d            = StEval;
        end
      end
      StRead: begin
        map_req_o.rd_en    = 1'b1;
        map_req_o.rd_addr  = sym_q;
        ring_req_o.rd_en   = 1'b1;
        ring_req_o.rd_addr = head_q;
        state_d            = StEval;
      end
      StEval: begin
        if (!final_step) begin
          // extra retire after the cooldown was lowered
          map_req_o.clr_en   = !ent_idle;
          map_req_o.clr_addr = ent_sym;
          head_d             = head_nx;
          count_d            = count_nx;
          state_d            = StRead;
        end else if (emit_ok) begin
          head_d              = head_nx;
          count_d             = count_nx + ics_pkg::CntW'(1);
          ring_req_o.wr_en    = 1'b1;
          ring_req_o.wr_addr  = head_nx + count_nx[ics_pkg::RingAw-1:0];
          out_v_d             = 1'b1;
          map_req_o.clr_addr  = ent_sym;
          if (busy) begin
            // idle slot
            ring_req_o.wr_data = {1'b1, {ics_pkg::SymW{1'b0}}};
            map_req_o.clr_en   = retire && !ent_idle;
            out_sym_d          = '0;
            out_idle_d         = 1'b1;
            out_last_d         = 1'b0;
            state_d            = StRead;
          end else begin
            // task slot, a set of the same symbol overrides its clear
            ring_req_o.wr_data = {1'b0, sym_q};
            map_req_o.set_en   = 1'b1;
            map_req_o.set_addr = sym_q;
            map_req_o.clr_en   = retire && !ent_idle && (ent_sym != sym_q);
            out_sym_d          = sym_q;
            out_idle_d         = 1'b0;
            out_last_d         = 1'b1;
            state_d            = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    out_sym_q  <= out_sym_d;
    out_idle_q <= out_idle_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign out_sym_o   = out_sym_q;
  assign out_idle_o  = out_idle_q;
  assign out_last_o  = out_last_q;

endmodule

@@ rtl/in_order_cooldown_scheduler_unit.sv @@
// top level of the in-order cooldown scheduler
// Usage: task symbols enter on the s_axis channel (tdata = symbol), one item
// per handshake, strictly in order. For each task the m_axis channel gives
// zero or more idle slots (tuser = 1, tdata = 0) and then the task slot
// itself (tuser = 0, tdata = symbol, tlast = 1). A task is held back until
// its symbol is absent from the last cooldown slots issued.
// The cooldown register lies at APB byte address 0; write it only while
// the block is idle. pready is always high.
// Steps: each slot takes a read of the ring and bitmap memories and an
// evaluate step that retires, decides and writes back. For an item's first
// slot the reads start in the accept cycle and the evaluate step follows
// at once. The next item is taken only after the current task slot is
// evaluated. Each extra retire after the cooldown was lowered adds a read and an evaluate step.
// Reset clears the window, the presence bitmap valid bits and the cooldown.
// When the receiver stalls the slot waits in the output register and the
// evaluate step holds until the register frees up; nothing is dropped.
module in_order_cooldown_scheduler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] task_symbol
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] slot_symbol
  output logic                      m_axis_tuser,  // [0] slot_idle
  output logic                      m_axis_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ics_pkg::ApbAw-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [ics_pkg::CdW-1:0]    cooldown;
  ics_pkg::map_req_t          map_req;
  logic                       map_present;
  ics_pkg::ring_req_t         ring_req;
  logic [ics_pkg::EntryW-1:0] ring_rdata;

  ics_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cooldown_o (cooldown)
  );

  ics_ring_ram u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  ics_present_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .present_o (map_present)
  );

  ics_slot_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cooldown_i    (cooldown),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_sym_i      (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sym_o     (m_axis_tdata),
    .out_idle_o    (m_axis_tuser),
    .out_last_o    (m_axis_tlast),
    .map_req_o     (map_req),
    .map_present_i (map_present),
    .ring_req_o    (ring_req),
    .ring_rdata_i  (ring_rdata)
  );

endmodule

@@ rtl/ics_checker.sv @@
// port-level checks for the cooldown scheduler and their binding
module ics_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // the task slot is never an idle slot
  a_last_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("task slot flagged idle");

  // idle slots carry a zero symbol and are never last
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'd0) && !m_axis_tlast)
    else $error("idle slot with symbol or last flag");

  // taking an item makes the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while the previous one is in flight");

  // a stalled slot keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("slot changed while stalled");

endmodule

bind in_order_cooldown_scheduler_unit ics_checker u_ics_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
